// File: hdl/rsa_pkg.sv
package rsa_pkg;

  // fixed field widths of the ports
  localparam int W_SAMPLE = 16;
  localparam int W_COUNT  = 32;
  localparam int W_SUM    = 48;
  localparam int W_SUMSQ  = 62;
  localparam int W_EXT    = 16;
  localparam int W_MEAN   = 24;
  localparam int W_VAR    = 38;
  localparam int W_SD     = 23;

  // internal widths
  localparam int X_W    = 24;
  localparam int OPND_W = 64;
  localparam int WIDE_W = 112;
  localparam int ROOT_W = 32;
  localparam int SREM_W = 36;
  localparam int ITER_W = 7;

  // iteration counts of the shared serial units
  localparam int ITER_MEAN = 64;
  localparam int ITER_N    = 32;
  localparam int ITER_SS   = 48;
  localparam int ITER_VAR  = 112;
  localparam int ITER_SQ   = 32;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MEAN_LD, ST_MEAN_RUN, ST_MEAN_ST,
    ST_MA_LD, ST_MA_RUN, ST_MA_ST,
    ST_MB_LD, ST_MB_RUN, ST_MB_ST,
    ST_MD_LD, ST_MD_RUN,
    ST_VAR_LD, ST_VAR_RUN, ST_VAR_ST,
    ST_SQ_LD, ST_SQ_RUN, ST_SQ_ST,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCUM,
    OP_MEAN_LD,
    OP_DIV_STEP,
    OP_MEAN_ST,
    OP_MUL_NS_LD,
    OP_MUL_STEP,
    OP_A_ST,
    OP_MUL_SS_LD,
    OP_NUM_ST,
    OP_MUL_NN_LD,
    OP_VAR_LD,
    OP_VAR_ST,
    OP_SQ_LD,
    OP_SQ_STEP,
    OP_SD_ST,
    OP_OUT_LD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic iter_last;
  } stat_t;

endpackage

// File: hdl/rsa_ctrl.sv
module rsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rsa_pkg::stat_t stat,
  output rsa_pkg::cmd_t cmd
);

  rsa_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != rsa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsa_pkg::ST_IDLE:     if (in_valid) state_nxt = rsa_pkg::ST_MEAN_LD;
      rsa_pkg::ST_MEAN_LD:  state_nxt = rsa_pkg::ST_MEAN_RUN;
      rsa_pkg::ST_MEAN_RUN: if (stat.iter_last) state_nxt = rsa_pkg::ST_MEAN_ST;
      rsa_pkg::ST_MEAN_ST:  state_nxt = rsa_pkg::ST_MA_LD;
      rsa_pkg::ST_MA_LD:    state_nxt = rsa_pkg::ST_MA_RUN;
      rsa_pkg::ST_MA_RUN:   if (stat.iter_last) state_nxt = rsa_pkg::ST_MA_ST;
      rsa_pkg::ST_MA_ST:    state_nxt = rsa_pkg::ST_MB_LD;
      rsa_pkg::ST_MB_LD:    state_nxt = rsa_pkg::ST_MB_RUN;
      rsa_pkg::ST_MB_RUN:   if (stat.iter_last) state_nxt = rsa_pkg::ST_MB_ST;
      rsa_pkg::ST_MB_ST:    state_nxt = rsa_pkg::ST_MD_LD;
      rsa_pkg::ST_MD_LD:    state_nxt = rsa_pkg::ST_MD_RUN;
      rsa_pkg::ST_MD_RUN:   if (stat.iter_last) state_nxt = rsa_pkg::ST_VAR_LD;
      rsa_pkg::ST_VAR_LD:   state_nxt = rsa_pkg::ST_VAR_RUN;
      rsa_pkg::ST_VAR_RUN:  if (stat.iter_last) state_nxt = rsa_pkg::ST_VAR_ST;
      rsa_pkg::ST_VAR_ST:   state_nxt = rsa_pkg::ST_SQ_LD;
      rsa_pkg::ST_SQ_LD:    state_nxt = rsa_pkg::ST_SQ_RUN;
      rsa_pkg::ST_SQ_RUN:   if (stat.iter_last) state_nxt = rsa_pkg::ST_SQ_ST;
      rsa_pkg::ST_SQ_ST:    state_nxt = rsa_pkg::ST_DONE;
      rsa_pkg::ST_DONE:     if (out_free) state_nxt = rsa_pkg::ST_IDLE;
      default:              state_nxt = rsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = rsa_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      rsa_pkg::ST_IDLE:     if (in_valid) cmd.op = rsa_pkg::OP_ACCUM;
      rsa_pkg::ST_MEAN_LD:  cmd.op = rsa_pkg::OP_MEAN_LD;
      rsa_pkg::ST_MEAN_RUN: cmd.op = rsa_pkg::OP_DIV_STEP;
      rsa_pkg::ST_MEAN_ST:  cmd.op = rsa_pkg::OP_MEAN_ST;
      rsa_pkg::ST_MA_LD:    cmd.op = rsa_pkg::OP_MUL_NS_LD;
      rsa_pkg::ST_MA_RUN:   cmd.op = rsa_pkg::OP_MUL_STEP;
      rsa_pkg::ST_MA_ST:    cmd.op = rsa_pkg::OP_A_ST;
      rsa_pkg::ST_MB_LD:    cmd.op = rsa_pkg::OP_MUL_SS_LD;
      rsa_pkg::ST_MB_RUN:   cmd.op = rsa_pkg::OP_MUL_STEP;
      rsa_pkg::ST_MB_ST:    cmd.op = rsa_pkg::OP_NUM_ST;
      rsa_pkg::ST_MD_LD:    cmd.op = rsa_pkg::OP_MUL_NN_LD;
      rsa_pkg::ST_MD_RUN:   cmd.op = rsa_pkg::OP_MUL_STEP;
      rsa_pkg::ST_VAR_LD:   cmd.op = rsa_pkg::OP_VAR_LD;
      rsa_pkg::ST_VAR_RUN:  cmd.op = rsa_pkg::OP_DIV_STEP;
      rsa_pkg::ST_VAR_ST:   cmd.op = rsa_pkg::OP_VAR_ST;
      rsa_pkg::ST_SQ_LD:    cmd.op = rsa_pkg::OP_SQ_LD;
      rsa_pkg::ST_SQ_RUN:   cmd.op = rsa_pkg::OP_SQ_STEP;
      rsa_pkg::ST_SQ_ST:    cmd.op = rsa_pkg::OP_SD_ST;
      rsa_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.op        = rsa_pkg::OP_OUT_LD;
          out_valid_nxt = 1'b1;
        end
      end
      default:              cmd.op = rsa_pkg::OP_NONE;
    endcase
  end

endmodule

// File: hdl/rsa_datapath.sv
module rsa_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rsa_pkg::cmd_t                       cmd,
  output rsa_pkg::stat_t                      stat,
  input  logic [rsa_pkg::W_SAMPLE-1:0]        in_sample_value,
  output logic [rsa_pkg::W_COUNT-1:0]         out_sample_count,
  output logic signed [rsa_pkg::W_SUM-1:0]    out_running_sum,
  output logic [rsa_pkg::W_SUMSQ-1:0]         out_running_sum_sq,
  output logic signed [rsa_pkg::W_EXT-1:0]    out_smallest,
  output logic signed [rsa_pkg::W_EXT-1:0]    out_largest,
  output logic signed [rsa_pkg::W_MEAN-1:0]   out_mean_q8,
  output logic [rsa_pkg::W_VAR-1:0]           out_variance_q8,
  output logic [rsa_pkg::W_SD-1:0]            out_stdev_q8,
  output logic                                out_saturated
);

  localparam int XW = rsa_pkg::X_W;
  localparam int OW = rsa_pkg::OPND_W;
  localparam int WW = rsa_pkg::WIDE_W;
  localparam int SX = XW - SAMPLE_BITS;
  localparam logic [rsa_pkg::W_COUNT-1:0] CMAX =
    rsa_pkg::W_COUNT'((64'd1 << COUNT_BITS) - 64'd1);

  // accumulated state
  logic [rsa_pkg::W_COUNT-1:0] count_r;
  logic [rsa_pkg::W_SUM-1:0]   sum_r;
  logic [rsa_pkg::W_SUMSQ-1:0] sumsq_r;
  logic signed [XW-1:0]        min_r, max_r;
  logic                        sat_r;

  // shared serial units
  logic [rsa_pkg::ITER_W-1:0]  cnt_r;
  logic [WW-1:0]               macc_r;
  logic [OW-1:0]               ma_r, mb_r;
  logic [WW-1:0]               dnum_r;
  logic [OW-1:0]               drem_r, dden_r;
  logic [WW-1:0]               prod_a_r;
  logic [OW-1:0]               srad_r;
  logic [rsa_pkg::SREM_W-1:0]  srem_r;
  logic [rsa_pkg::ROOT_W-1:0]  sroot_r;

  // derived results
  logic [rsa_pkg::W_MEAN-1:0]  mean_r;
  logic [rsa_pkg::W_VAR-1:0]   var_r;
  logic [rsa_pkg::W_SD-1:0]    sd_r;

  // result word
  logic [rsa_pkg::W_COUNT-1:0] o_count_r;
  logic [rsa_pkg::W_SUM-1:0]   o_sum_r;
  logic [rsa_pkg::W_SUMSQ-1:0] o_sumsq_r;
  logic [rsa_pkg::W_EXT-1:0]   o_min_r, o_max_r;
  logic [rsa_pkg::W_MEAN-1:0]  o_mean_r;
  logic [rsa_pkg::W_VAR-1:0]   o_var_r;
  logic [rsa_pkg::W_SD-1:0]    o_sd_r;
  logic                        o_sat_r;

  logic [XW-1:0]               xz, xm;
  logic signed [XW-1:0]        x;
  logic [2*XW-1:0]             xsq;
  logic                        full;
  logic                        sneg;
  logic [rsa_pkg::W_SUM-1:0]   smag;
  logic [OW-1:0]               mean_num, mean_q;
  logic [OW:0]                 drem2, dsub;
  logic                        dge;
  logic [WW-1:0]               msum, ndiff;
  logic [rsa_pkg::SREM_W-1:0]  qrem2, qtrial;
  logic                        qge;

  assign xz   = XW'(in_sample_value);
  // mask to the sample width and sign extend from its top bit
  assign x    = $signed(xz << SX) >>> SX;
  assign xm   = x[XW-1] ? XW'(-x) : XW'(x);
  assign xsq  = xm * xm;
  assign full = (count_r == CMAX);

  assign sneg     = sum_r[rsa_pkg::W_SUM-1];
  assign smag     = sneg ? (rsa_pkg::W_SUM'(0) - sum_r) : sum_r;
  // negative mean rounds toward minus infinity: ceil the magnitude
  assign mean_num = (OW'(smag) << FRAC_BITS)
                  + (sneg ? (OW'(count_r) - OW'(1)) : OW'(0));
  assign mean_q   = sneg ? (OW'(0) - dnum_r[OW-1:0]) : dnum_r[OW-1:0];

  assign drem2 = {drem_r, dnum_r[WW-1]};
  assign dsub  = drem2 - {1'b0, dden_r};
  assign dge   = (drem2 >= {1'b0, dden_r});

  assign msum  = {macc_r[WW-2:0], 1'b0} + (mb_r[OW-1] ? WW'(ma_r) : WW'(0));
  assign ndiff = prod_a_r - macc_r;

  assign qrem2  = {srem_r[rsa_pkg::SREM_W-3:0], srad_r[OW-1:OW-2]};
  assign qtrial = {2'b00, sroot_r, 2'b01};
  assign qge    = (qrem2 >= qtrial);

  assign stat.iter_last = (cnt_r == rsa_pkg::ITER_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      sat_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      case (cmd.op)
        rsa_pkg::OP_ACCUM: begin
          sat_r <= full;
          if (!full) begin
            count_r <= count_r + rsa_pkg::W_COUNT'(1);
            sum_r   <= sum_r + {{(rsa_pkg::W_SUM-XW){x[XW-1]}}, x};
            sumsq_r <= sumsq_r + rsa_pkg::W_SUMSQ'(xsq);
            if (count_r == '0) begin
              min_r <= x;
              max_r <= x;
            end else begin
              if (x < min_r) min_r <= x;
              if (x > max_r) max_r <= x;
            end
          end
        end
        rsa_pkg::OP_MEAN_LD: begin
          dnum_r <= {mean_num, (WW-OW)'(0)};
          drem_r <= '0;
          dden_r <= OW'(count_r);
          cnt_r  <= rsa_pkg::ITER_W'(rsa_pkg::ITER_MEAN);
        end
        rsa_pkg::OP_DIV_STEP: begin
          drem_r <= dge ? dsub[OW-1:0] : drem2[OW-1:0];
          dnum_r <= {dnum_r[WW-2:0], dge};
          cnt_r  <= cnt_r - rsa_pkg::ITER_W'(1);
        end
        rsa_pkg::OP_MEAN_ST: mean_r <= mean_q[rsa_pkg::W_MEAN-1:0];
        rsa_pkg::OP_MUL_NS_LD: begin
          macc_r <= '0;
          ma_r   <= OW'(sumsq_r);
          mb_r   <= {count_r, (OW-rsa_pkg::W_COUNT)'(0)};
          cnt_r  <= rsa_pkg::ITER_W'(rsa_pkg::ITER_N);
        end
        rsa_pkg::OP_MUL_STEP: begin
          macc_r <= msum;
          mb_r   <= {mb_r[OW-2:0], 1'b0};
          cnt_r  <= cnt_r - rsa_pkg::ITER_W'(1);
        end
        rsa_pkg::OP_A_ST: prod_a_r <= macc_r;
        rsa_pkg::OP_MUL_SS_LD: begin
          macc_r <= '0;
          ma_r   <= OW'(smag);
          mb_r   <= {smag, (OW-rsa_pkg::W_SUM)'(0)};
          cnt_r  <= rsa_pkg::ITER_W'(rsa_pkg::ITER_SS);
        end
        rsa_pkg::OP_NUM_ST: begin
          // a negative numerator only arises from wrapped totals
          prod_a_r <= (prod_a_r < macc_r) ? WW'(0) : (ndiff << FRAC_BITS);
        end
        rsa_pkg::OP_MUL_NN_LD: begin
          macc_r <= '0;
          ma_r   <= OW'(count_r);
          mb_r   <= {count_r, (OW-rsa_pkg::W_COUNT)'(0)};
          cnt_r  <= rsa_pkg::ITER_W'(rsa_pkg::ITER_N);
        end
        rsa_pkg::OP_VAR_LD: begin
          dnum_r <= prod_a_r;
          drem_r <= '0;
          dden_r <= macc_r[OW-1:0];
          cnt_r  <= rsa_pkg::ITER_W'(rsa_pkg::ITER_VAR);
        end
        rsa_pkg::OP_VAR_ST: begin
          var_r <= (|dnum_r[WW-1:rsa_pkg::W_VAR]) ? '1 : dnum_r[rsa_pkg::W_VAR-1:0];
        end
        rsa_pkg::OP_SQ_LD: begin
          srad_r  <= OW'(var_r) << FRAC_BITS;
          srem_r  <= '0;
          sroot_r <= '0;
          cnt_r   <= rsa_pkg::ITER_W'(rsa_pkg::ITER_SQ);
        end
        rsa_pkg::OP_SQ_STEP: begin
          srem_r  <= qge ? (qrem2 - qtrial) : qrem2;
          sroot_r <= {sroot_r[rsa_pkg::ROOT_W-2:0], qge};
          srad_r  <= {srad_r[OW-3:0], 2'b00};
          cnt_r   <= cnt_r - rsa_pkg::ITER_W'(1);
        end
        rsa_pkg::OP_SD_ST: begin
          sd_r <= (|sroot_r[rsa_pkg::ROOT_W-1:rsa_pkg::W_SD]) ? '1
                : sroot_r[rsa_pkg::W_SD-1:0];
        end
        rsa_pkg::OP_OUT_LD: begin
          o_count_r <= count_r;
          o_sum_r   <= sum_r;
          o_sumsq_r <= sumsq_r;
          o_min_r   <= min_r[rsa_pkg::W_EXT-1:0];
          o_max_r   <= max_r[rsa_pkg::W_EXT-1:0];
          o_mean_r  <= mean_r;
          o_var_r   <= var_r;
          o_sd_r    <= sd_r;
          o_sat_r   <= sat_r;
        end
        default: ;
      endcase
    end
  end

  assign out_sample_count   = o_count_r;
  assign out_running_sum    = $signed(o_sum_r);
  assign out_running_sum_sq = o_sumsq_r;
  assign out_smallest       = $signed(o_min_r);
  assign out_largest        = $signed(o_max_r);
  assign out_mean_q8        = $signed(o_mean_r);
  assign out_variance_q8    = o_var_r;
  assign out_stdev_q8       = o_sd_r;
  assign out_saturated      = o_sat_r;

endmodule

// File: hdl/running_statistics_accumulator_core.sv
// channel  | direction | ports
// in       | input     | in_valid, in_stall, in_sample_value
// out      | output    | out_valid, out_stall, out_sample_count .. out_saturated
//
// after acceptance each word runs through one shared
// restoring divider (64 steps for the mean, 112 for the variance), one
// shift-add multiplier (32 + 48 + 32 steps) and a 32-step square root.
// rst_n is synchronous and clears the totals; no clearing pass.
// a stalled result waits in its own register; the next word is taken
// meanwhile and only its result waits for that register to free up.
module running_statistics_accumulator_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 32,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rsa_pkg::W_SAMPLE-1:0]        in_sample_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rsa_pkg::W_COUNT-1:0]         out_sample_count,
  output logic signed [rsa_pkg::W_SUM-1:0]    out_running_sum,
  output logic [rsa_pkg::W_SUMSQ-1:0]         out_running_sum_sq,
  output logic signed [rsa_pkg::W_EXT-1:0]    out_smallest,
  output logic signed [rsa_pkg::W_EXT-1:0]    out_largest,
  output logic signed [rsa_pkg::W_MEAN-1:0]   out_mean_q8,
  output logic [rsa_pkg::W_VAR-1:0]           out_variance_q8,
  output logic [rsa_pkg::W_SD-1:0]            out_stdev_q8,
  output logic                                out_saturated
);

  rsa_pkg::cmd_t  cmd;
  rsa_pkg::stat_t stat;

  rsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsa_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_sample_value    (in_sample_value),
    .out_sample_count   (out_sample_count),
    .out_running_sum    (out_running_sum),
    .out_running_sum_sq (out_running_sum_sq),
    .out_smallest       (out_smallest),
    .out_largest        (out_largest),
    .out_mean_q8        (out_mean_q8),
    .out_variance_q8    (out_variance_q8),
    .out_stdev_q8       (out_stdev_q8),
    .out_saturated      (out_saturated)
  );

endmodule

// File: hdl/rsa_checker.sv
module rsa_checker #(
  parameter int COUNT_BITS = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [rsa_pkg::W_COUNT-1:0]       out_sample_count,
  input logic signed [rsa_pkg::W_EXT-1:0]  out_smallest,
  input logic signed [rsa_pkg::W_EXT-1:0]  out_largest,
  input logic [rsa_pkg::W_VAR-1:0]         out_variance_q8,
  input logic [rsa_pkg::W_SD-1:0]          out_stdev_q8,
  input logic                              out_saturated
);

  localparam logic [rsa_pkg::W_COUNT-1:0] CMAX =
    rsa_pkg::W_COUNT'((64'd1 << COUNT_BITS) - 64'd1);

  // one word in flight: the input closes right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input still open after a word was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_count))
    else $error("stalled result word changed");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_smallest <= out_largest)
    else $error("minimum above maximum");

  a_single_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_count == 1 |-> out_variance_q8 == 0 && out_stdev_q8 == 0)
    else $error("nonzero spread for a single sample");

  a_sat_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_sample_count == CMAX)
    else $error("saturated flag without a full count");

endmodule

bind running_statistics_accumulator_core rsa_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_rsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample_count (out_sample_count),
  .out_smallest     (out_smallest),
  .out_largest      (out_largest),
  .out_variance_q8  (out_variance_q8),
  .out_stdev_q8     (out_stdev_q8),
  .out_saturated    (out_saturated)
);
